/* design/tx_slot_priority_arbiter_defines.svh */
// Assertion macros for the transmit slot arbiter top level.
`ifndef TX_SLOT_PRIORITY_ARBITER_DEFINES_SVH
`define TX_SLOT_PRIORITY_ARBITER_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked outside reset.
`define TXSA_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked in every cycle, reset included.
`define TXSA_ASSERT_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`else

`define TXSA_ASSERT(name, prop, msg)
`define TXSA_ASSERT_RST(name, prop, msg)

`endif

`endif

/* design/txsa_pkg.sv */
// Shared types, widths and helpers for the transmit slot arbiter.
package txsa_pkg;

   localparam int SLOT_COUNT_DEF = 4;

   localparam int PRIO_W   = 2;
   localparam int CLASS_W  = 2;
   localparam int KIND_W   = 3;
   localparam int LEN_W    = 8;
   localparam int SEQ_W    = 16;
   localparam int STARV_W  = 16;
   localparam int TIME_W   = 32;
   localparam int IDX_W    = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_TOO_BIG = 2'd2
   } txsa_status_type;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } txsa_op_type;

   // Ordering key of one slot, as seen by the compare unit.
   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [CLASS_W-1:0] cls;
      logic [STARV_W-1:0] starv;
      logic [TIME_W-1:0]  created;
   } txsa_key_type;

   // Starvation count step that saturates at all ones.
   function automatic logic [STARV_W-1:0] bump_count(input logic [STARV_W-1:0] c);
      bump_count = (c == '1) ? c : c + STARV_W'(1);
   endfunction

endpackage

/* design/txsa_cmp.sv */
// Shared slot compare unit: tells whether a candidate slot outranks the current best.
module txsa_cmp
   import txsa_pkg::*;
(
   input  txsa_key_type cand,
   input  txsa_key_type best,
   output logic         beats
);

   // Lower priority wins, then lower class, then more starvation, then older.
   always_comb begin
      priority if (cand.prio != best.prio) begin
         beats = cand.prio < best.prio;
      end else if (cand.cls != best.cls) begin
         beats = cand.cls < best.cls;
      end else if (cand.starv != best.starv) begin
         beats = cand.starv > best.starv;
      end else begin
         beats = cand.created < best.created;
      end
   end

endmodule

/* design/tx_slot_priority_arbiter.sv */
// Top level of the transmit slot arbiter with starvation aging.
//
// Usage: drive an item on the req_ ports and raise start while busy is low;
// the item is taken at that clock edge. req_operation selects an enqueue
// (write one slot) or a dequeue (pick the best present slot and release it
// if its frame fits req_dest_capacity). Exactly one result comes back per
// item: rsp_valid is high for one cycle with the rsp_ fields, and the
// receiver must take it then, as it cannot stall the block.
// Sequence: an enqueue goes from idle to the finish state, which writes its
// slot and registers the result. A dequeue walks the slots one per cycle
// through a single compare unit, then commits in the finish state, which
// registers its result. busy is low again in the cycle that shows the
// result, so the next item may start right then. One item is in flight
// at a time.
// Reset (synchronous, active high) marks every slot empty, returns the
// sequencer to idle and drops rsp_valid; slot contents are not cleared.
`include "tx_slot_priority_arbiter_defines.svh"

module tx_slot_priority_arbiter
   import txsa_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [IDX_W-1:0]    req_slot_index,
   input  logic [PRIO_W-1:0]   req_priority_level,
   input  logic [CLASS_W-1:0]  req_effort_class,
   input  logic [KIND_W-1:0]   req_packet_kind,
   input  logic [LEN_W-1:0]    req_frame_length,
   input  logic [TIME_W-1:0]   req_now_time,
   input  logic [SEQ_W-1:0]    req_ref_sequence,
   input  logic [LEN_W-1:0]    req_dest_capacity,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status_code,
   output logic [IDX_W-1:0]    rsp_winner_slot,
   output logic [KIND_W-1:0]   rsp_out_packet_kind,
   output logic [LEN_W-1:0]    rsp_out_frame_length,
   output logic [SEQ_W-1:0]    rsp_out_ref_sequence,
   output logic                rsp_any_pending
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      txsa_op_type        op;
      logic [IDX_W-1:0]   slot;
      logic [PRIO_W-1:0]  prio;
      logic [CLASS_W-1:0] cls;
      logic [KIND_W-1:0]  kind;
      logic [LEN_W-1:0]   len;
      logic [TIME_W-1:0]  now;
      logic [SEQ_W-1:0]   seq;
      logic [LEN_W-1:0]   cap;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [SLOT_W-1:0]  idx;
      txsa_key_type       key;
      logic [LEN_W-1:0]   len;
      logic [KIND_W-1:0]  kind;
      logic [SEQ_W-1:0]   seq;
   } best_type;

   // Slot storage.
   logic [SLOT_COUNT-1:0] present_ff, present_in;
   logic [PRIO_W-1:0]     prio_ff    [SLOT_COUNT];
   logic [PRIO_W-1:0]     prio_in    [SLOT_COUNT];
   logic [CLASS_W-1:0]    class_ff   [SLOT_COUNT];
   logic [CLASS_W-1:0]    class_in   [SLOT_COUNT];
   logic [KIND_W-1:0]     kind_ff    [SLOT_COUNT];
   logic [KIND_W-1:0]     kind_in    [SLOT_COUNT];
   logic [SEQ_W-1:0]      seq_ff     [SLOT_COUNT];
   logic [SEQ_W-1:0]      seq_in     [SLOT_COUNT];
   logic [LEN_W-1:0]      len_ff     [SLOT_COUNT];
   logic [LEN_W-1:0]      len_in     [SLOT_COUNT];
   logic [STARV_W-1:0]    starv_ff   [SLOT_COUNT];
   logic [STARV_W-1:0]    starv_in   [SLOT_COUNT];
   logic [TIME_W-1:0]     created_ff [SLOT_COUNT];
   logic [TIME_W-1:0]     created_in [SLOT_COUNT];

   // Sequencer and result registers.
   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] scan_ff, scan_in;
   req_type           req_ff, req_in;
   best_type          best_ff, best_in;
   logic              rsp_valid_ff, rsp_valid_in;
   txsa_status_type   rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]  rsp_winner_ff, rsp_winner_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [SEQ_W-1:0]  rsp_seq_ff, rsp_seq_in;
   logic              rsp_any_ff, rsp_any_in;

   txsa_key_type cand_key;
   logic         cand_beats;
   logic         too_big;
   logic         enq_commit;
   logic         deq_commit;

   // Candidate slot read at the scan pointer.
   always_comb begin
      cand_key.prio    = prio_ff[scan_ff];
      cand_key.cls     = class_ff[scan_ff];
      cand_key.starv   = starv_ff[scan_ff];
      cand_key.created = created_ff[scan_ff];
   end

   txsa_cmp u_cmp (
      .cand  (cand_key),
      .best  (best_ff.key),
      .beats (cand_beats)
   );

   // Commit conditions of the finishing cycle.
   always_comb begin
      too_big    = best_ff.len > req_ff.cap;
      enq_commit = (state_ff == ST_FINISH) && (req_ff.op == OP_ENQUEUE)
                   && (int'(req_ff.slot) < SLOT_COUNT);
      deq_commit = (state_ff == ST_FINISH) && (req_ff.op == OP_DEQUEUE)
                   && best_ff.found && !too_big;
   end

   // Per-slot update: enqueue writes its slot (aging it if already present), a send frees the winner and ages the rest.
   always_comb begin
      present_in = present_ff;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         prio_in[i]    = prio_ff[i];
         class_in[i]   = class_ff[i];
         kind_in[i]    = kind_ff[i];
         seq_in[i]     = seq_ff[i];
         len_in[i]     = len_ff[i];
         starv_in[i]   = starv_ff[i];
         created_in[i] = created_ff[i];
         if (enq_commit && (int'(req_ff.slot) == i)) begin
            if (present_ff[i]) begin
               starv_in[i] = bump_count(starv_ff[i]);
            end else begin
               starv_in[i]   = '0;
               created_in[i] = req_ff.now;
            end
            present_in[i] = 1'b1;
            prio_in[i]    = req_ff.prio;
            class_in[i]   = req_ff.cls;
            kind_in[i]    = req_ff.kind;
            len_in[i]     = req_ff.len;
            seq_in[i]     = req_ff.seq;
         end else if (deq_commit) begin
            if (best_ff.idx == SLOT_W'(i)) begin
               present_in[i] = 1'b0;
            end else if (present_ff[i]) begin
               starv_in[i] = bump_count(starv_ff[i]);
            end
         end
      end
   end

   // Slot registers; only the presence bits need a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else begin
         present_ff <= present_in;
      end
      prio_ff    <= prio_in;
      class_ff   <= class_in;
      kind_ff    <= kind_in;
      seq_ff     <= seq_in;
      len_ff     <= len_in;
      starv_ff   <= starv_in;
      created_ff <= created_in;
   end

   // Sequencer: take an item, walk the slots for a dequeue, then commit and report.
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      req_in        = req_ff;
      best_in       = best_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_winner_in = rsp_winner_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_any_in    = rsp_any_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in.op     = txsa_op_type'(req_operation);
               req_in.slot   = req_slot_index;
               req_in.prio   = req_priority_level;
               req_in.cls    = req_effort_class;
               req_in.kind   = req_packet_kind;
               req_in.len    = req_frame_length;
               req_in.now    = req_now_time;
               req_in.seq    = req_ref_sequence;
               req_in.cap    = req_dest_capacity;
               best_in.found = 1'b0;
               scan_in       = '0;
               state_in      = (req_operation == OP_DEQUEUE) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (present_ff[scan_ff] && (!best_ff.found || cand_beats)) begin
               best_in.found = 1'b1;
               best_in.idx   = scan_ff;
               best_in.key   = cand_key;
               best_in.len   = len_ff[scan_ff];
               best_in.kind  = kind_ff[scan_ff];
               best_in.seq   = seq_ff[scan_ff];
            end
            if (scan_ff == SLOT_W'(SLOT_COUNT - 1)) begin
               state_in = ST_FINISH;
            end else begin
               scan_in = scan_ff + SLOT_W'(1);
            end
         end
         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_DONE;
            rsp_winner_in = '0;
            rsp_kind_in   = '0;
            rsp_len_in    = '0;
            rsp_seq_in    = '0;
            rsp_any_in    = |present_in;
            if (req_ff.op == OP_DEQUEUE) begin
               if (!best_ff.found) begin
                  rsp_status_in = STATUS_EMPTY;
               end else if (too_big) begin
                  rsp_status_in = STATUS_TOO_BIG;
                  rsp_winner_in = IDX_W'(best_ff.idx);
               end else begin
                  rsp_winner_in = IDX_W'(best_ff.idx);
                  rsp_kind_in   = best_ff.kind;
                  rsp_len_in    = best_ff.len;
                  rsp_seq_in    = best_ff.seq;
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff       <= scan_in;
      req_ff        <= req_in;
      best_ff       <= best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_winner_ff <= rsp_winner_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_any_ff    <= rsp_any_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status_code      = rsp_status_ff;
   assign rsp_winner_slot      = rsp_winner_ff;
   assign rsp_out_packet_kind  = rsp_kind_ff;
   assign rsp_out_frame_length = rsp_len_ff;
   assign rsp_out_ref_sequence = rsp_seq_ff;
   assign rsp_any_pending      = rsp_any_ff;

   // A result strobe only follows a finishing cycle.
   `TXSA_ASSERT(a_rsp_after_finish, rsp_valid |-> $past(state_ff == ST_FINISH), "result strobe without a finishing cycle")
   // A frame that does not fit leaves every slot in place.
   `TXSA_ASSERT(a_blocked_keeps_slots, rsp_valid && (rsp_status_code == STATUS_TOO_BIG) |-> $stable(present_ff), "blocked frame changed slot presence")
   // An empty report means no slot is held.
   `TXSA_ASSERT(a_empty_means_none, rsp_valid && (rsp_status_code == STATUS_EMPTY) |-> !rsp_any_pending && (present_ff == '0), "empty report with slots held")
   // The slot walk never leaves the slot range.
   `TXSA_ASSERT(a_scan_in_range, (state_ff == ST_SCAN) |-> (int'(scan_ff) < SLOT_COUNT), "scan pointer beyond last slot")
   // Right after reset the block is idle and silent.
   `TXSA_ASSERT_RST(a_reset_idle, $past(reset) |-> !busy && !rsp_valid, "block active right after reset")

endmodule
